@@ rtl/core/euler_pose_error_core_assert.svh @@
// assertion macros used by the checker file
`ifndef EULER_POSE_ERROR_CORE_ASSERT_SVH
`define EULER_POSE_ERROR_CORE_ASSERT_SVH

// condition holds in the same cycle
`define EPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define EPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/epe_pkg.sv @@
// types, constants and arithmetic helpers of the pose error core
`default_nettype none
package epe_pkg;
	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;

	// angle scaling into q30 and range reduction sizes
	localparam int ANG_SHIFT = 30 - FRAC_BITS;
	localparam int RED_N     = 31 - FRAC_BITS;
	localparam int VW        = 64 - FRAC_BITS;
	localparam int IW        = 5;

	localparam int ZW = 35;
	localparam int XW = 34;
	localparam int TW = 33;
	localparam int DW = 33;
	localparam int PW = TW + DW;
	localparam int RW = PW - 30;
	localparam int SW = 40;

	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] GAIN_Q30    = 64'd652032874;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} cordic_t;

	typedef struct packed {
		logic signed [31:0]   ex;
		logic signed [31:0]   ey;
		logic signed [31:0]   ez;
		logic signed [DW-1:0] dr;
		logic signed [DW-1:0] dp;
		logic signed [DW-1:0] dy;
	} side_t;

	// arctangent of 2^-i in q30, truncated
	function automatic logic [31:0] atan_q30(input logic [IW-1:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:    r = 32'd843314856;
			5'd1:    r = 32'd497837829;
			5'd2:    r = 32'd263043836;
			5'd3:    r = 32'd133525158;
			5'd4:    r = 32'd67021686;
			5'd5:    r = 32'd33543515;
			5'd6:    r = 32'd16775850;
			5'd7:    r = 32'd8388437;
			5'd8:    r = 32'd4194282;
			5'd9:    r = 32'd2097149;
			5'd10:   r = 32'd1048575;
			5'd11:   r = 32'd524287;
			5'd12:   r = 32'd262143;
			5'd13:   r = 32'd131071;
			5'd14:   r = 32'd65535;
			5'd15:   r = 32'd32767;
			5'd16:   r = 32'd16383;
			5'd17:   r = 32'd8191;
			5'd18:   r = 32'd4095;
			5'd19:   r = 32'd2047;
			5'd20:   r = 32'd1023;
			5'd21:   r = 32'd511;
			5'd22:   r = 32'd255;
			5'd23:   r = 32'd127;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// q30 product rounding, half up
	function automatic logic signed [RW-1:0] rnd_q30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + (PW'(1) << 29);
		return signed'(t[PW-1:30]);
	endfunction

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if ((&v[SW-1:31]) || !(|v[SW-1:31]))
			r = v[31:0];
		else if (v[SW-1])
			r = 32'sh80000000;
		else
			r = 32'sh7fffffff;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/euler_pose_error_core.sv @@
// top level of the pose error core
// Usage:
// - input channel in_valid / in_stall carries one target and actual pose per item,
//   output channel out_valid / out_stall carries the six error fields per item
// - an item is taken at an edge with valid high and stall low, one per cycle
// - the pipeline at the default settings: one ingress stage,
//   31 - FRAC_BITS angle reduction cells, one fold stage, CORDIC_STAGES cordic
//   cells, one sign stage, four multiply and output stages
// - throughput is one item per cycle while out_stall is low; every stage is a
//   register so nothing else limits the rate below the clock
// - the whole chain moves on a single enable: while a result sits in the output
//   register with out_stall high, the chain holds and in_stall is high
// - bubbles in the chain are carried along as cleared valid bits
// - reset clears all valid bits; the data registers are not reset
// - roll and pitch run through two parallel rows of cells, the position and
//   angle differences ride in a side delay line next to them
`default_nettype none
module euler_pose_error_core
	import epe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic signed [31:0] target_z,
	input  wire logic signed [31:0] target_roll,
	input  wire logic signed [31:0] target_pitch,
	input  wire logic signed [31:0] target_yaw,
	input  wire logic signed [31:0] actual_x,
	input  wire logic signed [31:0] actual_y,
	input  wire logic signed [31:0] actual_z,
	input  wire logic signed [31:0] actual_roll,
	input  wire logic signed [31:0] actual_pitch,
	input  wire logic signed [31:0] actual_yaw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      err_x,
	output logic signed [31:0]      err_y,
	output logic signed [31:0]      err_z,
	output logic signed [31:0]      err_rot_x,
	output logic signed [31:0]      err_rot_y,
	output logic signed [31:0]      err_rot_z
);
	localparam int POS_FOLD = RED_N + 1;
	localparam int POS_NEG  = POS_FOLD + CORDIC_STAGES + 1;
	localparam int TOT      = POS_NEG + 5;

	logic           en;
	logic [TOT-1:0] vld_q;
	side_t          side_q [POS_NEG+1];
	side_t          side_in;

	logic [VW-1:0] zr_in, zp_in;
	logic [VW-1:0] rv_r [RED_N+1];
	logic [VW-1:0] rv_p [RED_N+1];
	cordic_t       cr_row [CORDIC_STAGES+1];
	cordic_t       cp_row [CORDIC_STAGES+1];
	cordic_t       fold_r, fold_p;

	logic signed [TW-1:0] sr_s1, cr_s1, sp_s1, cp_s1;
	logic signed [PW-1:0] p_sc_s2, p_cc_s2, p_spdy_s2, p_crdp_s2, p_srdp_s2;
	side_t                sd_s2, sd_s3, sd_s4;
	logic signed [TW-1:0] sc_s3, cc_s3;
	logic signed [RW-1:0] m_spdy_s3, m_crdp_s3, m_srdp_s3;
	logic signed [RW-1:0] m_spdy_s4, m_crdp_s4, m_srdp_s4;
	logic signed [PW-1:0] p_scdy_s4, p_ccdy_s4;
	logic signed [31:0]   ex_s5, ey_s5, ez_s5, rx_s5, ry_s5, rz_s5;

	// single chain enable, held while the output item waits
	assign en       = !(vld_q[TOT-1] && out_stall);
	assign in_stall = !en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOT-2:0], in_valid};
	end

	// differences and q30 angles offset to stay non-negative
	always_comb begin
		side_in.ex = sat32(SW'(target_x) - SW'(actual_x));
		side_in.ey = sat32(SW'(target_y) - SW'(actual_y));
		side_in.ez = sat32(SW'(target_z) - SW'(actual_z));
		side_in.dr = DW'(target_roll) - DW'(actual_roll);
		side_in.dp = DW'(target_pitch) - DW'(actual_pitch);
		side_in.dy = DW'(target_yaw) - DW'(actual_yaw);
		zr_in = (VW'(actual_roll) << ANG_SHIFT) + (VW'(TWO_PI_Q30) << (RED_N - 1));
		zp_in = (VW'(actual_pitch) << ANG_SHIFT) + (VW'(TWO_PI_Q30) << (RED_N - 1));
	end

	// ingress stage and side delay line
	always_ff @(posedge clk) begin
		if (en) begin
			rv_r[0]   <= zr_in;
			rv_p[0]   <= zp_in;
			side_q[0] <= side_in;
			for (int i = 1; i <= POS_NEG; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// angle reduction rows, largest multiple of two pi first
	for (genvar j = 0; j < RED_N; j++) begin : g_red
		epe_red_cell u_red_r (
			.clk (clk),
			.en  (en),
			.idx (IW'(RED_N - 1 - j)),
			.v_i (rv_r[j]),
			.v_o (rv_r[j+1])
		);
		epe_red_cell u_red_p (
			.clk (clk),
			.en  (en),
			.idx (IW'(RED_N - 1 - j)),
			.v_i (rv_p[j]),
			.v_o (rv_p[j+1])
		);
	end

	// fold into minus half pi to half pi
	always_comb begin
		logic signed [ZW-1:0] zr, zp;
		zr = signed'(ZW'(rv_r[RED_N][32:0]));
		zp = signed'(ZW'(rv_p[RED_N][32:0]));
		if (zr >= signed'(ZW'(PI_Q30)))
			zr = zr - signed'(ZW'(TWO_PI_Q30));
		if (zp >= signed'(ZW'(PI_Q30)))
			zp = zp - signed'(ZW'(TWO_PI_Q30));
		fold_r.x   = XW'(GAIN_Q30);
		fold_r.y   = '0;
		fold_p.x   = XW'(GAIN_Q30);
		fold_p.y   = '0;
		fold_r.neg = 1'b1;
		fold_p.neg = 1'b1;
		if (zr > signed'(ZW'(HALF_PI_Q30)))
			fold_r.z = zr - signed'(ZW'(PI_Q30));
		else if (zr < -signed'(ZW'(HALF_PI_Q30)))
			fold_r.z = zr + signed'(ZW'(PI_Q30));
		else begin
			fold_r.z   = zr;
			fold_r.neg = 1'b0;
		end
		if (zp > signed'(ZW'(HALF_PI_Q30)))
			fold_p.z = zp - signed'(ZW'(PI_Q30));
		else if (zp < -signed'(ZW'(HALF_PI_Q30)))
			fold_p.z = zp + signed'(ZW'(PI_Q30));
		else begin
			fold_p.z   = zp;
			fold_p.neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_row[0] <= fold_r;
			cp_row[0] <= fold_p;
		end
	end

	// cordic rows
	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
		epe_cordic_cell u_cor_r (
			.clk (clk),
			.en  (en),
			.idx (IW'(j)),
			.c_i (cr_row[j]),
			.c_o (cr_row[j+1])
		);
		epe_cordic_cell u_cor_p (
			.clk (clk),
			.en  (en),
			.idx (IW'(j)),
			.c_i (cp_row[j]),
			.c_o (cp_row[j+1])
		);
	end

	// sign correction, then jacobian products and rounding
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1 <= TW'(cr_row[CORDIC_STAGES].neg ? -cr_row[CORDIC_STAGES].y
				: cr_row[CORDIC_STAGES].y);
			cr_s1 <= TW'(cr_row[CORDIC_STAGES].neg ? -cr_row[CORDIC_STAGES].x
				: cr_row[CORDIC_STAGES].x);
			sp_s1 <= TW'(cp_row[CORDIC_STAGES].neg ? -cp_row[CORDIC_STAGES].y
				: cp_row[CORDIC_STAGES].y);
			cp_s1 <= TW'(cp_row[CORDIC_STAGES].neg ? -cp_row[CORDIC_STAGES].x
				: cp_row[CORDIC_STAGES].x);

			p_sc_s2   <= PW'(sr_s1) * PW'(cp_s1);
			p_cc_s2   <= PW'(cr_s1) * PW'(cp_s1);
			p_spdy_s2 <= PW'(sp_s1) * PW'(side_q[POS_NEG].dy);
			p_crdp_s2 <= PW'(cr_s1) * PW'(side_q[POS_NEG].dp);
			p_srdp_s2 <= PW'(sr_s1) * PW'(side_q[POS_NEG].dp);
			sd_s2     <= side_q[POS_NEG];

			sc_s3     <= TW'(rnd_q30(p_sc_s2));
			cc_s3     <= TW'(rnd_q30(p_cc_s2));
			m_spdy_s3 <= rnd_q30(p_spdy_s2);
			m_crdp_s3 <= rnd_q30(p_crdp_s2);
			m_srdp_s3 <= rnd_q30(p_srdp_s2);
			sd_s3     <= sd_s2;

			p_scdy_s4 <= PW'(sc_s3) * PW'(sd_s3.dy);
			p_ccdy_s4 <= PW'(cc_s3) * PW'(sd_s3.dy);
			m_spdy_s4 <= m_spdy_s3;
			m_crdp_s4 <= m_crdp_s3;
			m_srdp_s4 <= m_srdp_s3;
			sd_s4     <= sd_s3;

			// output register
			ex_s5 <= sd_s4.ex;
			ey_s5 <= sd_s4.ey;
			ez_s5 <= sd_s4.ez;
			rx_s5 <= sat32(SW'(sd_s4.dr) + SW'(m_spdy_s4));
			ry_s5 <= sat32(SW'(m_crdp_s4) - SW'(rnd_q30(p_scdy_s4)));
			rz_s5 <= sat32(SW'(m_srdp_s4) + SW'(rnd_q30(p_ccdy_s4)));
		end
	end

	assign out_valid = vld_q[TOT-1];
	assign err_x     = ex_s5;
	assign err_y     = ey_s5;
	assign err_z     = ez_s5;
	assign err_rot_x = rx_s5;
	assign err_rot_y = ry_s5;
	assign err_rot_z = rz_s5;
endmodule
`default_nettype wire

@@ rtl/core/epe_red_cell.sv @@
// one step of the modulo two pi angle reduction chain
`default_nettype none
module epe_red_cell
	import epe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [IW-1:0] idx,
	input  wire logic [VW-1:0] v_i,
	output logic      [VW-1:0] v_o
);
	logic [VW-1:0] m;
	logic [VW-1:0] v_q;

	// two pi scaled by this step's power of two
	assign m = VW'(TWO_PI_Q30) << idx;

	// conditional subtract
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_i >= m)
				v_q <= v_i - m;
			else
				v_q <= v_i;
		end
	end

	assign v_o = v_q;
endmodule
`default_nettype wire

@@ rtl/core/epe_cordic_cell.sv @@
// one rotation-mode cordic iteration
`default_nettype none
module epe_cordic_cell
	import epe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [IW-1:0] idx,
	input  wire cordic_t       c_i,
	output cordic_t            c_o
);
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] at;
	cordic_t              c_q;

	assign xs = c_i.x >>> idx;
	assign ys = c_i.y >>> idx;
	assign at = signed'(ZW'(atan_q30(idx)));

	// rotate towards zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			c_q.neg <= c_i.neg;
			if (!c_i.z[ZW-1]) begin
				c_q.x <= c_i.x - ys;
				c_q.y <= c_i.y + xs;
				c_q.z <= c_i.z - at;
			end else begin
				c_q.x <= c_i.x + ys;
				c_q.y <= c_i.y - xs;
				c_q.z <= c_i.z + at;
			end
		end
	end

	assign c_o = c_q;
endmodule
`default_nettype wire

@@ rtl/core/epe_chk.sv @@
// port checker of the pose error core and its bind
`default_nettype none
`include "euler_pose_error_core_assert.svh"
module epe_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] err_x,
	input wire logic [31:0] err_rot_z
);
	// a stalled result item stays
	`EPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped")
	// a stalled result item keeps its value
	`EPE_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(err_x) && $stable(err_rot_z), "stalled result changed")
	// input is refused only while the output register is blocked
	`EPE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "spurious in_stall")
	// a blocked output register holds the whole chain
	`EPE_ASSERT_NOW(a_stall_prop, out_valid && out_stall, in_stall, "chain not held")
endmodule

bind euler_pose_error_core epe_chk u_epe_chk (.*);
`default_nettype wire

@@ sim/euler_pose_error_core_tb.sv @@
// self-checking testbench of the pose error core: directed table, then random poses
`timescale 1ns / 100ps
`default_nettype none
module euler_pose_error_core_tb;
	import epe_pkg::*;

	localparam int N_RANDOM   = 1600;
	localparam int WDOG_LIMIT = 20000;
	localparam int LATENCY    = 40;

	typedef struct {
		logic signed [31:0] t[6];
		logic signed [31:0] a[6];
	} pose_pair_t;

	typedef struct {
		logic signed [31:0] e[6];
	} pose_err_t;

	// directed row: poses, and an optional typed-in expectation
	typedef struct {
		pose_pair_t p;
		bit         fixed;
		pose_err_t  want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] tgt[6];
	logic signed [31:0] act[6];
	logic out_valid;
	logic out_stall;
	logic signed [31:0] err_x, err_y, err_z, err_rot_x, err_rot_y, err_rot_z;

	pose_err_t pending_errs[$];
	pose_pair_t stim_q[$];
	dir_row_t dir_tab[$];
	int n_fail;
	int idle_cycles;
	bit stim_done;
	bit rx_hold;

	euler_pose_error_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_x(tgt[0]), .target_y(tgt[1]), .target_z(tgt[2]),
		.target_roll(tgt[3]), .target_pitch(tgt[4]), .target_yaw(tgt[5]),
		.actual_x(act[0]), .actual_y(act[1]), .actual_z(act[2]),
		.actual_roll(act[3]), .actual_pitch(act[4]), .actual_yaw(act[5]),
		.out_valid(out_valid), .out_stall(out_stall),
		.err_x(err_x), .err_y(err_y), .err_z(err_z),
		.err_rot_x(err_rot_x), .err_rot_y(err_rot_y), .err_rot_z(err_rot_z)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// floor division by 2^s
	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	// q30 product, round half up
	function automatic longint q30_mul(input longint a, input longint b);
		return floor_shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint atan_entry(input int i);
		longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127};
		return tab[i];
	endfunction

	// sine and cosine in q30 by rotation cordic after reduction and folding
	task automatic angle_sincos(input logic signed [31:0] ang, output longint s,
			output longint c);
		longint z, x, y, xs, ys;
		bit flip;
		z = longint'(ang) * (64'sd1 <<< (30 - FRAC_BITS));
		x = longint'(GAIN_Q30);
		y = 0;
		flip = 0;
		z = z % longint'(TWO_PI_Q30);
		if (z < 0)
			z += longint'(TWO_PI_Q30);
		if (z >= longint'(PI_Q30))
			z -= longint'(TWO_PI_Q30);
		if (z > longint'(HALF_PI_Q30)) begin
			z -= longint'(PI_Q30);
			flip = 1;
		end else if (z < -longint'(HALF_PI_Q30)) begin
			z += longint'(PI_Q30);
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_entry(i);
			end else begin
				x += ys;
				y -= xs;
				z += atan_entry(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endtask

	// pose error of one pose pair
	task automatic calc_pose_err(input pose_pair_t p, output pose_err_t r);
		longint d[6];
		longint sr, cr, sp, cp, sc, cc;
		for (int i = 0; i < 6; i++)
			d[i] = longint'(p.t[i]) - longint'(p.a[i]);
		angle_sincos(p.a[3], sr, cr);
		angle_sincos(p.a[4], sp, cp);
		sc = q30_mul(sr, cp);
		cc = q30_mul(cr, cp);
		r.e[0] = clamp32(d[0]);
		r.e[1] = clamp32(d[1]);
		r.e[2] = clamp32(d[2]);
		r.e[3] = clamp32(d[3] + q30_mul(sp, d[5]));
		r.e[4] = clamp32(q30_mul(cr, d[4]) - q30_mul(sc, d[5]));
		r.e[5] = clamp32(q30_mul(sr, d[4]) + q30_mul(cc, d[5]));
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		n_fail++;
	endtask

	function automatic logic signed [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 2000)) - 1000;
			3: return $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_pair_t rand_pair();
		pose_pair_t p;
		for (int i = 0; i < 6; i++) begin
			p.t[i] = rand_field();
			p.a[i] = ($urandom_range(0, 3) == 0) ? rand_field()
				: p.t[i] + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
		end
		return p;
	endfunction

	function automatic pose_pair_t all_same(input logic signed [31:0] tv,
			input logic signed [31:0] av);
		pose_pair_t p;
		for (int i = 0; i < 6; i++) begin
			p.t[i] = tv;
			p.a[i] = av;
		end
		return p;
	endfunction

	// directed table
	task automatic build_table();
		dir_row_t row;
		pose_err_t z;
		pose_err_t hi;
		for (int i = 0; i < 6; i++) begin
			z.e[i] = 0;
			hi.e[i] = 32'sh7fffffff;
		end
		// zero poses give zero error
		row = '{p: all_same(0, 0), fixed: 1, want: z};
		dir_tab.push_back(row);
		// positional saturation at both ends
		row.p = all_same(32'sh7fffffff, 32'sh80000000);
		row.fixed = 0;
		dir_tab.push_back(row);
		row.p = all_same(32'sh80000000, 32'sh7fffffff);
		dir_tab.push_back(row);
		// equal poses at extremes: no difference
		row.p = all_same(32'sh7fffffff, 32'sh7fffffff);
		row.fixed = 1;
		row.want = z;
		dir_tab.push_back(row);
		row.p = all_same(32'sh80000000, 32'sh80000000);
		dir_tab.push_back(row);
		// roll and pitch zero, so the jacobian is identity and saturates plainly
		row.p = all_same(32'sh7fffffff, 32'sh80000000);
		row.p.a[3] = 0;
		row.p.a[4] = 0;
		row.p.t[3] = 32'sh7fffffff;
		row.p.t[4] = 32'sh7fffffff;
		row.want = hi;
		row.want.e[4] = 32'sh7fffffff;
		row.fixed = 0;
		dir_tab.push_back(row);
		// angles near pi, half pi and huge multiples of two pi
		for (int k = 0; k < 14; k++) begin
			logic signed [31:0] angs[14] = '{32'sh0003_2440, -32'sh0003_2440,
				32'sh0001_921f, -32'sh0001_921f, 32'sh0001_9220, 32'sh0006_4880,
				-32'sh0006_4880, 32'sh0003_243f, 32'sh7fff_0000, 32'sh8001_0000,
				1, -1, 32'sh0000_c90f, 32'sh0004_b660};
			row.p = all_same(32'sh0001_0000, 0);
			row.p.a[3] = angs[k];
			row.p.a[4] = angs[13 - k];
			row.p.t[3] = angs[k] + 32'sh0000_8000;
			row.p.t[4] = angs[13 - k] - 32'sh0000_4000;
			row.p.t[5] = 32'sh0002_0000;
			row.fixed = 0;
			dir_tab.push_back(row);
		end
	endtask

	// sender
	initial begin
		dir_row_t row;
		pose_pair_t p;
		pose_err_t w;
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		stim_done = 0;
		n_fail = 0;
		for (int i = 0; i < 6; i++) begin
			tgt[i] = 0;
			act[i] = 0;
		end
		build_table();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int n = 0; n < dir_tab.size() + N_RANDOM; n++) begin
			if (n < dir_tab.size()) begin
				row = dir_tab[n];
				p = row.p;
				if (row.fixed)
					w = row.want;
				else
					calc_pose_err(p, w);
			end else begin
				p = rand_pair();
				calc_pose_err(p, w);
			end
			// one pause until the pipe is empty
			if (n == dir_tab.size() + 800) begin
				wait (pending_errs.size() == 0);
				@(negedge clk);
			end
			gap = ((n / 200) % 2 == 1) ? 0 : $urandom_range(0, 5);
			repeat (gap) @(negedge clk);
			tgt = p.t;
			act = p.a;
			in_valid = 1'b1;
			do @(posedge clk); while (in_stall);
			pending_errs.push_back(w);
			@(negedge clk);
			in_valid = 1'b0;
		end
		stim_done = 1;
	end

	// receiver: random stalls, one long hold-off after reset
	initial begin
		rx_hold = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		repeat (300) @(negedge clk);
		rx_hold = 1;
		out_stall = 1'b1;
		repeat (120) @(negedge clk);
		rx_hold = 0;
		forever begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			out_stall = (gap != 0);
			repeat (gap) @(negedge clk);
			out_stall = 1'b0;
			do @(negedge clk); while (!out_valid);
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		pose_err_t w;
		logic signed [31:0] got[6];
		if (arst_n && out_valid && !out_stall) begin
			got = '{err_x, err_y, err_z, err_rot_x, err_rot_y, err_rot_z};
			if (pending_errs.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				n_fail++;
			end else begin
				w = pending_errs.pop_front();
				for (int i = 0; i < 6; i++)
					if (got[i] !== w.e[i])
						report_mismatch($sformatf("field %0d", i), got[i], w.e[i]);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || rx_hold
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		fork
			begin
				wait (stim_done && pending_errs.size() == 0);
				repeat (LATENCY) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WDOG_LIMIT);
				$display("watchdog expired");
				n_fail++;
			end
		join_any
		if (n_fail == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
